// ----- src/sha1mh_pkg.sv -----
package sha1mh_pkg;

  localparam int BLOCK_WORDS  = 16;
  localparam int DIGEST_WORDS = 5;

  localparam logic [5:0] FILL_LAST   = 6'd63;
  localparam logic [5:0] LEN_FILL    = 6'd56;
  localparam logic [6:0] ROUND_LAST  = 7'd79;
  localparam logic [2:0] WORD_LAST   = 3'(DIGEST_WORDS - 1);
  localparam logic [7:0] PAD_MARK    = 8'h80;

  localparam logic [31:0] H_INIT [DIGEST_WORDS] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };

  typedef enum logic {
    CMD_ABSORB = 1'b0,
    CMD_FINISH = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MARK,
    ST_ZERO,
    ST_LEN,
    ST_ROUND,
    ST_FINAL,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    BSEL_DATA,
    BSEL_MARK,
    BSEL_ZERO,
    BSEL_LEN
  } bsel_t;

  typedef struct packed {
    logic  push;
    bsel_t bsel;
    logic  capture_len;
    logic  start_block;
    logic  round_step;
    logic  chain_add;
    logic  emit;
    logic  restart;
  } dp_cmd_t;

  typedef struct packed {
    logic [5:0] fill;
    logic       round_last;
    logic       out_free;
    logic       emit_last;
  } dp_status_t;

  function automatic logic [31:0] round_f(input logic [6:0] rnd, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    if (rnd < 7'd20) begin
      f = (b & c) | (~b & d);
    end else if (rnd < 7'd40) begin
      f = b ^ c ^ d;
    end else if (rnd < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

  function automatic logic [31:0] round_k(input logic [6:0] rnd);
    logic [31:0] k;
    if (rnd < 7'd20) begin
      k = 32'h5a827999;
    end else if (rnd < 7'd40) begin
      k = 32'h6ed9eba1;
    end else if (rnd < 7'd60) begin
      k = 32'h8f1bbcdc;
    end else begin
      k = 32'hca62c1d6;
    end
    return k;
  endfunction

endpackage

// ----- src/sha1mh_msg_if.sv -----
interface sha1mh_msg_if;
  import sha1mh_pkg::*;

  logic       valid;
  logic       ready;
  op_t        cmd;
  logic [7:0] data_byte;

  modport source (output valid, output cmd, output data_byte, input ready);
  modport sink (input valid, input cmd, input data_byte, output ready);
endinterface

// ----- src/sha1mh_digest_if.sv -----
interface sha1mh_digest_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last;

  modport source (output valid, output digest_word, output word_index, output last,
                  input ready);
  modport sink (input valid, input digest_word, input word_index, input last,
                output ready);
endinterface

// ----- src/sha1mh_ctrl.sv -----
module sha1mh_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  sha1mh_pkg::op_t        in_cmd,
  output logic                   in_ready,
  input  sha1mh_pkg::dp_status_t status,
  output sha1mh_pkg::dp_cmd_t    cmd
);
  import sha1mh_pkg::*;

  state_t st;
  state_t st_next;
  logic   finishing;
  logic   len_done;
  logic   block_full;

  assign block_full = (status.fill == FILL_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_IDLE;
      finishing <= 1'b0;
      len_done  <= 1'b0;
    end else begin
      st <= st_next;
      if (cmd.capture_len) begin
        finishing <= 1'b1;
      end
      if (st == ST_LEN && block_full) begin
        len_done <= 1'b1;
      end
      if (cmd.restart) begin
        finishing <= 1'b0;
        len_done  <= 1'b0;
      end
    end
  end

  // next state
  always_comb begin
    st_next = st;
    case (st)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_cmd == CMD_FINISH) begin
            st_next = ST_MARK;
          end else if (block_full) begin
            st_next = ST_ROUND;
          end
        end
      end
      ST_MARK: begin
        st_next = block_full ? ST_ROUND : ST_ZERO;
      end
      ST_ZERO: begin
        if (status.fill == LEN_FILL) begin
          st_next = ST_LEN;
        end else if (block_full) begin
          st_next = ST_ROUND;
        end
      end
      ST_LEN: begin
        if (block_full) begin
          st_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (status.round_last) begin
          st_next = ST_FINAL;
        end
      end
      ST_FINAL: begin
        if (!finishing) begin
          st_next = ST_IDLE;
        end else if (len_done) begin
          st_next = ST_EMIT;
        end else begin
          st_next = ST_ZERO;
        end
      end
      ST_EMIT: begin
        if (status.out_free && status.emit_last) begin
          st_next = ST_IDLE;
        end
      end
      default: st_next = ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    cmd.bsel = BSEL_DATA;
    case (st)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_cmd == CMD_FINISH) begin
            cmd.capture_len = 1'b1;
          end else begin
            cmd.push        = 1'b1;
            cmd.start_block = block_full;
          end
        end
      end
      ST_MARK: begin
        cmd.push        = 1'b1;
        cmd.bsel        = BSEL_MARK;
        cmd.start_block = block_full;
      end
      ST_ZERO: begin
        cmd.bsel = BSEL_ZERO;
        if (status.fill != LEN_FILL) begin
          cmd.push        = 1'b1;
          cmd.start_block = block_full;
        end
      end
      ST_LEN: begin
        cmd.push        = 1'b1;
        cmd.bsel        = BSEL_LEN;
        cmd.start_block = block_full;
      end
      ST_ROUND: begin
        cmd.round_step = 1'b1;
      end
      ST_FINAL: begin
        cmd.chain_add = 1'b1;
      end
      ST_EMIT: begin
        cmd.emit    = status.out_free;
        cmd.restart = status.out_free && status.emit_last;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ----- src/sha1mh_datapath.sv -----
module sha1mh_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [7:0]             data_byte,
  input  sha1mh_pkg::dp_cmd_t    cmd,
  output sha1mh_pkg::dp_status_t status,
  sha1mh_digest_if.source        digest
);
  import sha1mh_pkg::*;

  logic [31:0] blk [BLOCK_WORDS];
  logic [31:0] chain [DIGEST_WORDS];
  logic [31:0] wa, wb, wc, wd, we;
  logic [5:0]  fill;
  logic [63:0] total;
  logic [63:0] len_sh;
  logic [6:0]  rnd;
  logic [2:0]  eidx;
  logic        out_valid;
  logic [31:0] out_word;
  logic [2:0]  out_index;
  logic        out_last;
  logic [7:0]  byte_in;
  logic [31:0] sched_mix;
  logic [31:0] sched_new;
  logic [31:0] t_sum;

  always_comb begin
    case (cmd.bsel)
      BSEL_DATA: byte_in = data_byte;
      BSEL_MARK: byte_in = PAD_MARK;
      BSEL_ZERO: byte_in = 8'h00;
      BSEL_LEN:  byte_in = len_sh[63:56];
      default:   byte_in = 8'h00;
    endcase
  end

  assign sched_mix = blk[13] ^ blk[8] ^ blk[2] ^ blk[0];
  assign sched_new = {sched_mix[30:0], sched_mix[31]};
  assign t_sum     = {wa[26:0], wa[31:27]} + round_f(rnd, wb, wc, wd) + we
                     + round_k(rnd) + blk[0];

  // message shift line, doubles as the schedule window
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
        blk[i] <= {blk[i][23:0], blk[i + 1][31:24]};
      end
      blk[BLOCK_WORDS - 1] <= {blk[BLOCK_WORDS - 1][23:0], byte_in};
    end else if (cmd.round_step) begin
      for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
        blk[i] <= blk[i + 1];
      end
      blk[BLOCK_WORDS - 1] <= sched_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture_len) begin
      len_sh <= {total[60:0], 3'b000};
    end else if (cmd.push && cmd.bsel == BSEL_LEN) begin
      len_sh <= {len_sh[55:0], 8'h00};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_block) begin
      wa <= chain[0];
      wb <= chain[1];
      wc <= chain[2];
      wd <= chain[3];
      we <= chain[4];
    end else if (cmd.round_step) begin
      wa <= t_sum;
      wb <= wa;
      wc <= {wb[1:0], wb[31:2]};
      wd <= wc;
      we <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIGEST_WORDS; i++) begin
        chain[i] <= H_INIT[i];
      end
      fill      <= '0;
      total     <= '0;
      rnd       <= '0;
      eidx      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.push) begin
        fill <= fill + 6'd1;
        if (cmd.bsel == BSEL_DATA) begin
          total <= total + 64'd1;
        end
      end
      if (cmd.start_block) begin
        rnd <= '0;
      end else if (cmd.round_step) begin
        rnd <= rnd + 7'd1;
      end
      if (cmd.chain_add) begin
        chain[0] <= chain[0] + wa;
        chain[1] <= chain[1] + wb;
        chain[2] <= chain[2] + wc;
        chain[3] <= chain[3] + wd;
        chain[4] <= chain[4] + we;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (digest.ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.restart) begin
        eidx <= '0;
      end else if (cmd.emit) begin
        eidx <= eidx + 3'd1;
      end
      if (cmd.restart) begin
        for (int i = 0; i < DIGEST_WORDS; i++) begin
          chain[i] <= H_INIT[i];
        end
        total <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_word  <= chain[eidx];
      out_index <= eidx;
      out_last  <= (eidx == WORD_LAST);
    end
  end

  assign status.fill       = fill;
  assign status.round_last = (rnd == ROUND_LAST);
  assign status.out_free   = !out_valid || digest.ready;
  assign status.emit_last  = (eidx == WORD_LAST);

  assign digest.valid       = out_valid;
  assign digest.digest_word = out_word;
  assign digest.word_index  = out_index;
  assign digest.last        = out_last;

endmodule

// ----- src/sha1_message_hasher.sv -----
// SHA-1 over a byte stream. Absorb transfers shift bytes into the block; every 64th
// byte then starts a compression (80 rounds, one per cycle, plus the chaining
// add), during which msg.ready is low. A finish transfer feeds the padding bytes
// one per cycle outside compressions (pausing on reaching the length field), runs
// one or two compressions and then returns the five digest words, word 0 first,
// one per cycle while digest.ready is high; the block is back to its initial
// values for a new message as the last word is loaded. The compressions, during
// which no bytes are taken, set the sustained byte rate.
module sha1_message_hasher (
  input  logic            clk,
  input  logic            rst,
  sha1mh_msg_if.sink      msg,
  sha1mh_digest_if.source digest
);
  import sha1mh_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_ready;

  assign msg.ready = in_ready;

  sha1mh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (msg.valid),
    .in_cmd   (msg.cmd),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  sha1mh_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .data_byte (msg.data_byte),
    .cmd       (cmd),
    .status    (status),
    .digest    (digest)
  );

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> status.out_free)
    else $error("output register loaded while occupied");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    (digest.valid && digest.last) |-> (digest.word_index == WORD_LAST))
    else $error("last mark on wrong digest word");

  a_add_after_rounds: assert property (@(posedge clk) disable iff (rst)
    cmd.chain_add |-> $past(cmd.round_step && status.round_last))
    else $error("chaining add without completed rounds");

endmodule

// ----- tb/sv/sha1_message_hasher_tb.sv -----
`timescale 1ns / 100ps

module sha1_message_hasher_tb;
  import sha1mh_pkg::*;

  localparam int unsigned TOTAL_ITEMS  = 400;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned SETTLE_CYCLES = 300;

  localparam logic [31:0] SHA1_IV [5] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };
  localparam logic [31:0] K_CH  = 32'h5a827999;
  localparam logic [31:0] K_PAR = 32'h6ed9eba1;
  localparam logic [31:0] K_MAJ = 32'h8f1bbcdc;
  localparam logic [31:0] K_END = 32'hca62c1d6;
  localparam logic [7:0]  PAD_BYTE   = 8'h80;
  localparam logic [5:0]  LEN_OFFSET = 6'd56;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last;
  } digest_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sha1mh_msg_if    msg_bus ();
  sha1mh_digest_if digest_bus ();

  sha1_message_hasher dut (
    .clk    (clk),
    .rst    (rst),
    .msg    (msg_bus),
    .digest (digest_bus)
  );

  always #5 clk = ~clk;

  logic [31:0] hash_chain [5];
  logic [7:0]  hash_block [64];
  logic [5:0]  hash_fill;
  logic [63:0] hash_byte_total;

  digest_word_t pending_digest_words [$];

  int unsigned items_sent;
  int unsigned messages_done;
  int unsigned words_checked;
  int unsigned error_count;
  int unsigned cycle_count;
  bit          src_idle_on;
  bit          sink_idle_on;

  function automatic void hash_restart();
    for (int i = 0; i < 5; i++) hash_chain[i] = SHA1_IV[i];
    hash_fill       = 6'd0;
    hash_byte_total = 64'd0;
  endfunction

  function automatic void hash_compress();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int r = 0; r < 16; r++) begin
      w[r] = {hash_block[4*r], hash_block[4*r+1], hash_block[4*r+2], hash_block[4*r+3]};
    end
    for (int r = 16; r < 80; r++) begin
      t    = w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16];
      w[r] = {t[30:0], t[31]};
    end
    a = hash_chain[0];
    b = hash_chain[1];
    c = hash_chain[2];
    d = hash_chain[3];
    e = hash_chain[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = K_CH;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = K_PAR;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K_MAJ;
      end else begin
        f = b ^ c ^ d;
        k = K_END;
      end
      t = {a[26:0], a[31:27]} + f + e + k + w[r];
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    hash_chain[0] += a;
    hash_chain[1] += b;
    hash_chain[2] += c;
    hash_chain[3] += d;
    hash_chain[4] += e;
  endfunction

  function automatic void hash_push_byte(input logic [7:0] v);
    hash_block[hash_fill] = v;
    hash_fill = hash_fill + 6'd1;
    if (hash_fill == 6'd0) hash_compress();
  endfunction

  function automatic void hash_model_step(input op_t op, input logic [7:0] data);
    logic [63:0]  bit_len;
    digest_word_t entry;
    if (op == CMD_ABSORB) begin
      hash_byte_total = hash_byte_total + 64'd1;
      hash_push_byte(data);
    end else begin
      bit_len = hash_byte_total << 3;
      hash_push_byte(PAD_BYTE);
      while (hash_fill != LEN_OFFSET) hash_push_byte(8'h00);
      for (int i = 0; i < 8; i++) hash_push_byte(bit_len[63 - 8*i -: 8]);
      for (int i = 0; i < 5; i++) begin
        entry.digest_word = hash_chain[i];
        entry.word_index  = 3'(i);
        entry.last        = (i == 4);
        pending_digest_words.push_back(entry);
      end
      hash_restart();
      messages_done++;
    end
  endfunction

  task automatic send_item(input op_t op, input logic [7:0] data);
    int unsigned gap;
    gap = src_idle_on ? $urandom_range(0, 10) : 0;
    if (gap != 0) begin
      msg_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    msg_bus.valid     <= 1'b1;
    msg_bus.cmd       <= op;
    msg_bus.data_byte <= data;
    do @(posedge clk); while (!msg_bus.ready);
    hash_model_step(op, data);
    items_sent++;
  endtask

  task automatic send_message(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) send_item(CMD_ABSORB, 8'($urandom_range(0, 255)));
    send_item(CMD_FINISH, 8'($urandom_range(0, 255)));
  endtask

  task automatic wait_digests_drained();
    msg_bus.valid <= 1'b0;
    do @(posedge clk); while (pending_digest_words.size() != 0);
  endtask

  task automatic test_empty_message();
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    send_item(CMD_FINISH, 8'hff);
    send_item(CMD_FINISH, 8'h00);
    wait_digests_drained();
  endtask

  task automatic test_short_messages();
    send_item(CMD_ABSORB, 8'h61);
    send_item(CMD_ABSORB, 8'h62);
    send_item(CMD_ABSORB, 8'h63);
    send_item(CMD_FINISH, 8'h5a);
    send_item(CMD_ABSORB, 8'h00);
    send_item(CMD_FINISH, 8'hff);
    send_item(CMD_ABSORB, 8'hff);
    send_item(CMD_FINISH, 8'h00);
    send_item(CMD_ABSORB, 8'h80);
    send_item(CMD_FINISH, 8'h80);
    send_item(CMD_ABSORB, 8'h55);
    send_item(CMD_ABSORB, 8'haa);
    send_item(CMD_FINISH, 8'h7f);
    wait_digests_drained();
  endtask

  task automatic test_block_boundaries();
    send_message(55);
    send_message(56);
    wait_digests_drained();
    send_message(64);
    wait_digests_drained();
  endtask

  task automatic test_back_to_back();
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    send_message(0);
    send_message(5);
    send_message(63);
    wait_digests_drained();
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  task automatic test_random_messages();
    int unsigned len;
    int unsigned count;
    count = 0;
    while (items_sent < TOTAL_ITEMS) begin
      src_idle_on  = ($urandom_range(0, 3) != 0);
      sink_idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 5) == 0) begin
        len = $urandom_range(50, 70);
      end else begin
        len = $urandom_range(0, 12);
      end
      send_message(len);
      count++;
      if (count % 5 == 0) wait_digests_drained();
    end
    wait_digests_drained();
  endtask

  // digest side: random stall before each transfer while sink_idle_on is set
  initial begin
    int unsigned stall;
    digest_bus.ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      stall = sink_idle_on ? $urandom_range(0, 10) : 0;
      if (stall != 0) begin
        digest_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      digest_bus.ready <= 1'b1;
      do @(posedge clk); while (!digest_bus.valid);
    end
  end

  always @(posedge clk) begin : digest_check
    digest_word_t want;
    if (!rst && digest_bus.valid && digest_bus.ready) begin
      if (pending_digest_words.size() == 0) begin
        error_count++;
        $display("%0t: unexpected digest transfer: word %h index %0d last %0b", $time,
                 digest_bus.digest_word, digest_bus.word_index, digest_bus.last);
      end else begin
        want = pending_digest_words.pop_front();
        words_checked++;
        if (digest_bus.digest_word !== want.digest_word) begin
          error_count++;
          $display("%0t: digest_word expected %h actual %h", $time,
                   want.digest_word, digest_bus.digest_word);
        end
        if (digest_bus.word_index !== want.word_index) begin
          error_count++;
          $display("%0t: word_index expected %0d actual %0d", $time,
                   want.word_index, digest_bus.word_index);
        end
        if (digest_bus.last !== want.last) begin
          error_count++;
          $display("%0t: last expected %0b actual %0b", $time, want.last, digest_bus.last);
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timed out with %0d digest words outstanding", $time,
             pending_digest_words.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    msg_bus.valid     <= 1'b0;
    msg_bus.cmd       <= CMD_ABSORB;
    msg_bus.data_byte <= 8'h00;
    items_sent    = 0;
    messages_done = 0;
    words_checked = 0;
    error_count   = 0;
    src_idle_on   = 1'b1;
    sink_idle_on  = 1'b1;
    for (int i = 0; i < 64; i++) hash_block[i] = 8'h00;
    hash_restart();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_empty_message();
    test_short_messages();
    test_block_boundaries();
    test_back_to_back();
    test_random_messages();

    wait_digests_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("run covered %0d messages from %0d byte and finish transfers,", messages_done,
             items_sent);
    $display("including empty and block-boundary lengths; %0d digest words checked",
             words_checked);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
